// ===== rtl/efr_pkg.sv =====
// Shared types and constants for the escaped frame receiver.
`default_nettype none

package efr_pkg;

  localparam int unsigned MaxFrameDef = 4096;
  localparam int unsigned LenW        = 13;
  localparam int unsigned CfgIdxW     = 2;
  localparam logic [7:0]  CodeFlip    = 8'hFF;

  localparam logic [7:0] StartReset  = 8'hAA;
  localparam logic [7:0] StopReset   = 8'hCC;
  localparam logic [7:0] EscapeReset = 8'hBB;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START  = 2'd0,
    REG_STOP   = 2'd1,
    REG_ESCAPE = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BADSUM   = 3'd2,
    KIND_DOUBLE   = 3'd3,
    KIND_STRAY    = 3'd4,
    KIND_ESCBAD   = 3'd5,
    KIND_OVERFLOW = 3'd6
  } kind_e;

  typedef struct packed {
    logic [7:0] start;
    logic [7:0] stop;
    logic [7:0] escape;
  } markers_t;

  typedef struct packed {
    logic            valid;
    kind_e           kind;
    logic [7:0]      data;
    logic [LenW-1:0] len;
    logic [7:0]      csum;
    logic [7:0]      rsum;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/efr_cfg_regs.sv =====
// Marker configuration registers of the escaped frame receiver.
`default_nettype none

module efr_cfg_regs
  import efr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  output markers_t                markers_o
);

  markers_t markers_q, markers_d;

  always_comb begin
    markers_d = markers_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START:  markers_d.start  = cfg_data_i;
        REG_STOP:   markers_d.stop   = cfg_data_i;
        REG_ESCAPE: markers_d.escape = cfg_data_i;
        default:    markers_d = markers_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      markers_q.start  <= StartReset;
      markers_q.stop   <= StopReset;
      markers_q.escape <= EscapeReset;
    end else begin
      markers_q <= markers_d;
    end
  end

  assign markers_o = markers_q;

endmodule

`default_nettype wire

// ===== rtl/efr_deframer.sv =====
// Frame state and per-byte decode: markers, escapes, checksum and length.
`default_nettype none

module efr_deframer
  import efr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  markers_t        markers_i,
  output result_t         result_o
);

  localparam int unsigned CntW = $clog2(MAX_FRAME + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_FRAME);

  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      last_q, last_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            take_en;
  logic [7:0]      take_val;
  logic            close_en;
  logic [CntW-1:0] len_cnt;
  logic [31:0]     len_wide;
  result_t         res;

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    sum_d      = sum_q;
    last_d     = last_q;
    cnt_d      = cnt_q;
    take_en    = 1'b0;
    take_val   = byte_i;
    close_en   = 1'b0;
    len_cnt    = cnt_q;
    res        = '0;
    res.kind   = KIND_DATA;

    priority if (byte_i == markers_i.start) begin
      if (in_frame_q) begin
        res.valid = 1'b1;
        res.kind  = (cnt_q == '0) ? KIND_DOUBLE : KIND_STRAY;
      end
      in_frame_d = 1'b1;
      esc_d      = 1'b0;
      sum_d      = '0;
      last_d     = '0;
      cnt_d      = '0;
    end else if (!in_frame_q) begin
      res.valid = 1'b0;
    end else if (esc_q) begin
      esc_d = 1'b0;
      priority if (byte_i == (markers_i.escape ^ CodeFlip)) begin
        take_en  = 1'b1;
        take_val = markers_i.escape;
      end else if (byte_i == (markers_i.start ^ CodeFlip)) begin
        take_en  = 1'b1;
        take_val = markers_i.start;
      end else if (byte_i == (markers_i.stop ^ CodeFlip)) begin
        take_en  = 1'b1;
        take_val = markers_i.stop;
      end else begin
        close_en  = 1'b1;
        res.valid = 1'b1;
        res.kind  = KIND_ESCBAD;
      end
    end else if (byte_i == markers_i.escape) begin
      esc_d = 1'b1;
    end else if (byte_i == markers_i.stop) begin
      close_en  = 1'b1;
      res.valid = 1'b1;
      res.csum  = sum_q - last_q;
      res.rsum  = last_q;
      res.kind  = (res.csum == last_q) ? KIND_GOOD : KIND_BADSUM;
    end else begin
      take_en = 1'b1;
    end

    if (take_en) begin
      res.valid = 1'b1;
      if (cnt_q >= CntMax) begin
        close_en = 1'b1;
        res.kind = KIND_OVERFLOW;
      end else begin
        sum_d    = sum_q + take_val;
        last_d   = take_val;
        cnt_d    = cnt_q + 1'b1;
        len_cnt  = cnt_d;
        res.kind = KIND_DATA;
        res.data = take_val;
      end
    end

    if (close_en) begin
      in_frame_d = 1'b0;
      esc_d      = 1'b0;
      sum_d      = '0;
      cnt_d      = '0;
    end

    len_wide = 32'(len_cnt);
    res.len  = len_wide[LenW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b0;
      sum_q      <= '0;
      last_q     <= '0;
      cnt_q      <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      sum_q      <= sum_d;
      last_q     <= last_d;
      cnt_q      <= cnt_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ===== rtl/escaped_frame_receiver.sv =====
// Top level of the escaped frame receiver: input stage, decode, result register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------------------
//   rx      | in        | in_valid_i / in_stall_o| rx_byte_i
//   result  | out       | out_valid_o/out_stall_i| kind_o data_byte_o frame_length_o
//           |           |                        | computed_sum_o received_sum_o
//   config  | in        | cfg_we_i               | cfg_index_i cfg_data_i
//
// One byte per cycle unless the result stalls; results are registered after the decode.
// Latency is set by the input register and the result register around the decode.
// Reset loads the default markers and leaves the block outside any frame.
// A stalled result holds the decode stage; the input register then stalls the link.
`default_nettype none

module escaped_frame_receiver
  import efr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [2:0]              kind_o,
  output logic [7:0]              data_byte_o,
  output logic [LenW-1:0]         frame_length_o,
  output logic [7:0]              computed_sum_o,
  output logic [7:0]              received_sum_o
);

  markers_t   markers;
  result_t    res;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       step;

  logic       out_valid_q, out_valid_d;
  result_t    out_res_q, out_res_d;

  efr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .markers_o   (markers)
  );

  efr_deframer #(
    .MAX_FRAME (MAX_FRAME)
  ) u_deframer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .markers_i (markers),
    .result_o  (res)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    if (advance) begin
      out_valid_d = step && res.valid;
      if (step && res.valid) begin
        out_res_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_res_q.kind;
  assign data_byte_o    = out_res_q.data;
  assign frame_length_o = out_res_q.len;
  assign computed_sum_o = out_res_q.csum;
  assign received_sum_o = out_res_q.rsum;

`ifndef SYNTHESIS
  a_good_sums_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_GOOD) |-> computed_sum_o == received_sum_o)
    else $error("good end with mismatched sums");

  a_data_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DATA) |-> frame_length_o != '0)
    else $error("data result with zero length");

  a_sums_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_GOOD) && (kind_o != KIND_BADSUM)
      |-> (computed_sum_o == '0) && (received_sum_o == '0))
    else $error("checksum fields set outside a frame end");

  a_data_only_for_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_DATA) |-> data_byte_o == '0)
    else $error("data byte set on a non-data result");

  a_stall_holds_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(in_byte_q))
    else $error("input stage lost its request while stalled");
`endif

endmodule

`default_nettype wire
